// ===== rtl/core/fpa_pkg.sv =====
// Package for the fixed-point ALU: operation and status codes, payload and
// pipeline stage types, rounding and saturation helpers. No dependencies.
package fpa_pkg;

   localparam int FRAC_BITS = 8;
   localparam int NumW      = 32 + FRAC_BITS;  // dividend width, |a| << FRAC_BITS
   localparam int RemW      = 33;              // divider partial remainder
   localparam int MagW      = 65;              // wide magnitude for clamping

   localparam logic [MagW-1:0] RoundHalf = (MagW'(1) << FRAC_BITS) >> 1;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_INC    = 4'd4,
      OP_DEC    = 4'd5,
      OP_MIN    = 4'd6,
      OP_MAX    = 4'd7,
      OP_CMP    = 4'd8,
      OP_TO_INT = 4'd9
   } op_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_SAT  = 2'd1,
      ST_DIV0 = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      KIND_SIMPLE = 2'd0,
      KIND_MUL    = 2'd1,
      KIND_DIV    = 2'd2
   } kind_type;

   typedef struct packed {
      logic [3:0]         req_type;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } fpa_req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      logic               is_less;
      logic               is_greater;
      logic               is_equal;
      logic [1:0]         status;
   } fpa_rsp_type;

   typedef struct packed {
      logic less;
      logic greater;
      logic equal;
   } flags_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic        neg;
      logic [31:0] simple_value;
      status_type  simple_status;
      flags_type   flags;
      logic [63:0] product;
      logic [RemW-1:0] rem;
      logic [NumW-1:0] nq;      // dividend bits out on top, quotient bits in below
      logic [31:0] divisor;
   } stage_type;

   typedef struct packed {
      logic [31:0] value;
      logic        sat;
   } clamp_type;

   function automatic logic [MagW-1:0] round_shift(input logic [MagW-1:0] mag);
      return (mag + RoundHalf) >> FRAC_BITS;
   endfunction

   function automatic clamp_type clamp32(input logic neg, input logic [MagW-1:0] mag);
      clamp_type c;
      c.sat   = 1'b0;
      c.value = mag[31:0];
      if (neg) begin
         if (mag > MagW'(33'h0_8000_0000)) begin
            c.sat   = 1'b1;
            c.value = 32'h8000_0000;
         end else begin
            c.value = 32'd0 - mag[31:0];
         end
      end else if (mag > MagW'(32'h7FFF_FFFF)) begin
         c.sat   = 1'b1;
         c.value = 32'h7FFF_FFFF;
      end
      return c;
   endfunction

   // Saturate a 33-bit two's complement sum to 32 bits.
   function automatic clamp_type sat33(input logic [32:0] s);
      clamp_type c;
      c.sat   = s[32] ^ s[31];
      c.value = c.sat ? (s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : s[31:0];
      return c;
   endfunction

endpackage

// ===== rtl/core/fpa_front.sv =====
// Entry stage: decode, flags, saturating add/sub/inc/dec, min/max, to_int,
// multiplier and divider setup. Depends on fpa_pkg.
module fpa_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                enable,
   input  logic                req_valid,
   input  fpa_pkg::fpa_req_type req_data,
   output fpa_pkg::stage_type  stage_out
);
   import fpa_pkg::*;

   stage_type   stage_ff, stage_in;
   logic [31:0] a, b, mag_a, mag_b;
   clamp_type   c;

   always_comb begin
      a     = req_data.operand_a;
      b     = req_data.operand_b;
      mag_a = a[31] ? 32'd0 - a : a;
      mag_b = b[31] ? 32'd0 - b : b;
      c     = '{value: 32'd0, sat: 1'b0};

      stage_in               = '0;
      stage_in.valid         = req_valid;
      stage_in.kind          = KIND_SIMPLE;
      stage_in.neg           = a[31] ^ b[31];
      stage_in.flags.less    = $signed(a) < $signed(b);
      stage_in.flags.greater = $signed(a) > $signed(b);
      stage_in.flags.equal   = a == b;
      stage_in.product       = 64'(mag_a) * 64'(mag_b);
      stage_in.rem           = '0;
      stage_in.nq            = NumW'(mag_a) << FRAC_BITS;
      stage_in.divisor       = mag_b;
      stage_in.simple_status = ST_OK;

      case (op_type'(req_data.req_type))
         OP_ADD:    c = sat33({a[31], a} + {b[31], b});
         OP_SUB:    c = sat33({a[31], a} - {b[31], b});
         OP_INC:    c = sat33({a[31], a} + 33'd1);
         OP_DEC:    c = sat33({a[31], a} - 33'd1);
         OP_MIN:    c.value = stage_in.flags.less ? a : b;
         OP_MAX:    c.value = stage_in.flags.greater ? a : b;
         OP_TO_INT: c = clamp32(a[31], round_shift(MagW'(mag_a)));
         OP_MUL:    stage_in.kind = KIND_MUL;
         OP_DIV: begin
            if (b == 32'd0) begin
               stage_in.simple_status = ST_DIV0;
               c.value = a[31] ? 32'h8000_0000 : (a == 32'd0 ? 32'd0 : 32'h7FFF_FFFF);
            end else begin
               stage_in.kind = KIND_DIV;
            end
         end
         default:   c.value = 32'd0;
      endcase

      stage_in.simple_value = c.value;
      if (c.sat) stage_in.simple_status = ST_SAT;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/core/fpa_div_step.sv =====
// One restoring-division step, registered; the top level chains one per
// quotient bit. Depends on fpa_pkg.
module fpa_div_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               enable,
   input  fpa_pkg::stage_type stage_in,
   output fpa_pkg::stage_type stage_out
);
   import fpa_pkg::*;

   stage_type       stage_ff, next_in;
   logic [RemW-1:0] shifted;
   logic            take;

   always_comb begin
      shifted = {stage_in.rem[RemW-2:0], stage_in.nq[NumW-1]};
      take    = shifted >= RemW'(stage_in.divisor);
      next_in = stage_in;
      next_in.rem = take ? shifted - RemW'(stage_in.divisor) : shifted;
      next_in.nq  = {stage_in.nq[NumW-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else if (enable) begin
         stage_ff <= next_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

// ===== rtl/core/fpa_back.sv =====
// Result stage: rounding and saturation for multiply and divide, result
// selection, output register. Depends on fpa_pkg.
module fpa_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 enable,
   input  fpa_pkg::stage_type   stage_in,
   output logic                 rsp_valid,
   output fpa_pkg::fpa_rsp_type rsp_data
);
   import fpa_pkg::*;

   fpa_rsp_type rsp_data_ff, rsp_data_in;
   logic        rsp_valid_ff;
   clamp_type   c_mul, c_div;
   logic        round_up;

   always_comb begin
      c_mul    = clamp32(stage_in.neg, round_shift({1'b0, stage_in.product}));
      round_up = {stage_in.rem, 1'b0} >= (RemW + 1)'(stage_in.divisor);
      c_div    = clamp32(stage_in.neg, MagW'(stage_in.nq) + MagW'(round_up));

      rsp_data_in.is_less    = stage_in.flags.less;
      rsp_data_in.is_greater = stage_in.flags.greater;
      rsp_data_in.is_equal   = stage_in.flags.equal;
      case (stage_in.kind)
         KIND_MUL: begin
            rsp_data_in.result_value = c_mul.value;
            rsp_data_in.status       = c_mul.sat ? ST_SAT : ST_OK;
         end
         KIND_DIV: begin
            rsp_data_in.result_value = c_div.value;
            rsp_data_in.status       = c_div.sat ? ST_SAT : ST_OK;
         end
         default: begin
            rsp_data_in.result_value = stage_in.simple_value;
            rsp_data_in.status       = stage_in.simple_status;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/core/fixed_point_alu_top.sv =====
// Top level of the pipelined signed fixed-point ALU (Q with FRAC_BITS fraction
// bits). Depends on fpa_pkg, fpa_front, fpa_div_step and fpa_back.
//
//   channel | ports              | payload
//   --------+--------------------+-------------------------------------------
//   request | req_valid/req_ready| req_data: req_type, operand_a, operand_b
//   result  | rsp_valid/rsp_ready| rsp_data: result_value, flags, status
//
// Every operation takes the same path through the pipe: one entry stage,
// one restoring divide step per quotient bit, one result stage.
// One transaction per cycle is accepted while results keep draining.
// Reset is synchronous and clears only the stage valid bits.
// A stalled result freezes the whole pipe (one shared enable); bubbles
// pass downstream whenever the output register is empty or being taken.
module fixed_point_alu_top (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  fpa_pkg::fpa_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output fpa_pkg::fpa_rsp_type rsp_data
);
   import fpa_pkg::*;

   logic      enable;
   stage_type pipe [NumW+1];   // pipe[0] from entry stage, pipe[k] after k steps

   // Advance when the output register is free or its transaction completes.
   assign enable    = !rsp_valid || rsp_ready;
   assign req_ready = enable;

   fpa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .req_valid (req_valid),
      .req_data  (req_data),
      .stage_out (pipe[0])
   );

   // Divider chain: every transaction passes it, non-divide payload rides along.
   for (genvar k = 0; k < NumW; k++) begin : g_div
      fpa_div_step u_step (
         .clock     (clock),
         .reset     (reset),
         .enable    (enable),
         .stage_in  (pipe[k]),
         .stage_out (pipe[k+1])
      );
   end

   fpa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .stage_in  (pipe[NumW]),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== rtl/core/fpa_checker.sv =====
// Port-level checker for fixed_point_alu_top, attached by bind.
// Depends on fpa_pkg.
module fpa_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input fpa_pkg::fpa_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input fpa_pkg::fpa_rsp_type rsp_data
);
   import fpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with empty output");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while pipe is frozen");

   a_flags_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $onehot({rsp_data.is_less, rsp_data.is_greater, rsp_data.is_equal}))
      else $error("comparison flags not exclusive");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("undefined status code");

endmodule

bind fixed_point_alu_top fpa_checker u_fpa_checker (.*);
